### sv/assert_macros.svh
// Assertion macros used by the top level of the page allocator.
// Depends on nothing; include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check sampled on the rising clock, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Depends on nothing; used by the used-map memory and the top level.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int unsigned WORD_BITS = 8;
    localparam int unsigned WB_LOG    = 3;
    localparam int unsigned PCW       = 4;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_QUERY   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SRCH  = 7'b0000100,
        S_MARK  = 7'b0001000,
        S_WALK  = 7'b0010000,
        S_QUERY = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

### sv/bpa_map_ram.sv
// Used-map memory: one write port, one read port with registered read data.
// Depends on bpa_pkg for the word width.
`timescale 1ns / 1ps

module bpa_map_ram #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned AW    = 9
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [bpa_pkg::WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [bpa_pkg::WORD_BITS-1:0] o_rdata
);
    import bpa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bitmap_page_allocator.sv
// Bitmap first-fit page-frame allocator, top level.
// Depends on bpa_pkg, bpa_map_ram and assert_macros.svh.
//
// Requests enter on i_valid/o_stall with i_func, i_first_page and i_page_count;
// one result per request leaves on o_valid/i_stall. The page limit register is
// written through i_cfg_valid/o_cfg_ready/i_cfg_data; the user must write it
// only while no request is in flight, as the block does not enforce this. The
// used map sits in a memory of 8-bit words, walked one word per cycle by a
// read-modify-write sequencer, one request at a time.
// A query reads the word of the asked page; free and release walk the words
// touched; alloc searches words up to the end of the fitting run, then marks
// the run's words. At the default of 4096 pages a full search covers 512 words.
// After reset the map is swept to all used, one word per cycle, while o_stall
// is high; the free count and allocation count reset to zero and the limit to
// 4096.
// A finished result is held in the output register while i_stall is high;
// the next request is still accepted, and its result waits until the held
// transaction has been taken.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
    parameter int unsigned NUM_PAGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_first_page,
    input  logic [12:0] i_page_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_page_number,
    output logic [12:0] o_pages_changed,
    output logic [12:0] o_free_count,
    output logic [31:0] o_alloc_total,
    output logic        o_page_is_free,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import bpa_pkg::*;
    `include "assert_macros.svh"

    localparam int unsigned PW     = $clog2(NUM_PAGES);
    localparam int unsigned CW     = PW + 1;
    localparam int unsigned NW     = (CW > 14) ? CW : 14;
    localparam int unsigned NWORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    t_state               r_state, n_state;
    logic [12:0]          r_limit;
    logic [AW-1:0]        r_addr, n_addr;
    logic [NW-1:0]        r_lo, n_lo, r_hi, n_hi, r_run, n_run, r_cnt, n_cnt;
    logic [11:0]          r_first, n_first;
    logic [CW-1:0]        r_chg, n_chg, r_free_cnt, n_free_cnt;
    logic [31:0]          r_alloc, n_alloc;
    t_status              r_res_status, n_res_status;
    logic [NW-1:0]        r_res_pnum, n_res_pnum;
    logic                 r_res_isfree, n_res_isfree;
    logic                 r_ovalid;
    t_status              r_o_status;
    logic [11:0]          r_o_pnum;
    logic [12:0]          r_o_chg, r_o_free;
    logic [31:0]          r_o_alloc;
    logic                 r_o_isfree;
    logic                 load_out;

    logic                 we;
    logic [WORD_BITS-1:0] wdata, rd_data;
    logic [NW-1:0]        eff_lim, base, sum_end;
    logic [NW-1:0]        s_run, s_fp, s_p;
    logic                 s_found, s_end;
    logic [WORD_BITS-1:0] w_mask, w_new;
    logic [PCW-1:0]       w_pop;
    logic                 w_last;

    assign eff_lim = (NW'(r_limit) > NW'(NUM_PAGES)) ? NW'(NUM_PAGES) : NW'(r_limit);
    assign base    = NW'({r_addr, {WB_LOG{1'b0}}});
    assign sum_end = NW'(i_first_page) + NW'(i_page_count);

    bpa_map_ram #(
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (n_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        s_run   = r_run;
        s_found = 1'b0;
        s_end   = 1'b0;
        s_fp    = '0;
        s_p     = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            s_p = base + NW'(b);
            if (!s_found && !s_end) begin
                if (s_p >= eff_lim) begin
                    s_end = 1'b1;
                end else begin
                    s_run = rd_data[b] ? '0 : s_run + NW'(1);
                    if (s_run == r_cnt) begin
                        s_found = 1'b1;
                        s_fp    = s_p;
                    end
                end
            end
        end
        if (base + NW'(WORD_BITS) >= eff_lim) begin
            s_end = 1'b1;
        end
    end

    always_comb begin
        w_pop = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            w_mask[b] = (base + NW'(b) >= r_lo) && (base + NW'(b) < r_hi);
            w_pop     = w_pop + PCW'(rd_data[b] & w_mask[b]);
        end
        w_new  = (r_state == S_MARK) ? (rd_data | w_mask) : (rd_data & ~w_mask);
        w_last = (base + NW'(WORD_BITS) >= r_hi);
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_run        = r_run;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_chg        = r_chg;
        n_free_cnt   = r_free_cnt;
        n_alloc      = r_alloc;
        n_res_status = r_res_status;
        n_res_pnum   = r_res_pnum;
        n_res_isfree = r_res_isfree;
        we           = 1'b0;
        wdata        = w_new;
        load_out     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                wdata  = '1;
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(NWORDS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_first      = i_first_page;
                    n_cnt        = NW'(i_page_count);
                    n_chg        = '0;
                    n_res_status = ST_OK;
                    n_res_pnum   = '0;
                    n_res_isfree = 1'b0;
                    n_run        = '0;
                    unique case (t_func'(i_func))
                        FUNC_ALLOC: begin
                            if (i_page_count == 13'd0) begin
                                n_res_status = ST_INVALID;
                                n_state      = S_DONE;
                            end else begin
                                n_addr  = '0;
                                n_state = S_SRCH;
                            end
                        end
                        FUNC_FREE, FUNC_RELEASE: begin
                            n_lo    = NW'(i_first_page);
                            n_hi    = (sum_end < eff_lim) ? sum_end : eff_lim;
                            n_addr  = AW'(i_first_page >> WB_LOG);
                            n_state = S_DONE;
                            if (t_func'(i_func) == FUNC_FREE &&
                                (i_first_page == 12'd0 || i_page_count == 13'd0)) begin
                                n_res_status = ST_INVALID;
                            end else if (NW'(i_first_page) < n_hi) begin
                                n_state = S_WALK;
                            end
                        end
                        FUNC_QUERY: begin
                            n_addr  = AW'(i_first_page >> WB_LOG);
                            n_state = S_QUERY;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SRCH: begin
                if (s_found) begin
                    n_lo       = s_fp + NW'(1) - r_cnt;
                    n_hi       = s_fp + NW'(1);
                    n_res_pnum = n_lo;
                    n_addr     = AW'(n_lo >> WB_LOG);
                    n_state    = S_MARK;
                end else if (s_end) begin
                    n_res_status = ST_NO_SPACE;
                    n_state      = S_DONE;
                end else begin
                    n_run  = s_run;
                    n_addr = r_addr + AW'(1);
                end
            end
            S_MARK: begin
                we     = 1'b1;
                n_addr = r_addr + AW'(1);
                if (w_last) begin
                    n_free_cnt = r_free_cnt - CW'(r_cnt);
                    n_chg      = CW'(r_cnt);
                    n_alloc    = r_alloc + 32'd1;
                    n_state    = S_DONE;
                end
            end
            S_WALK: begin
                we         = 1'b1;
                n_addr     = r_addr + AW'(1);
                n_chg      = r_chg + CW'(w_pop);
                n_free_cnt = r_free_cnt + CW'(w_pop);
                if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_QUERY: begin
                n_res_isfree = (NW'(r_first) < eff_lim) && !rd_data[r_first[WB_LOG-1:0]];
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_addr     <= '0;
            r_limit    <= 13'd4096;
            r_free_cnt <= '0;
            r_alloc    <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_free_cnt <= n_free_cnt;
            r_alloc    <= n_alloc;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_run        <= n_run;
        r_cnt        <= n_cnt;
        r_first      <= n_first;
        r_chg        <= n_chg;
        r_res_status <= n_res_status;
        r_res_pnum   <= n_res_pnum;
        r_res_isfree <= n_res_isfree;
        if (load_out) begin
            r_o_status <= r_res_status;
            r_o_pnum   <= 12'(r_res_pnum);
            r_o_chg    <= 13'(r_chg);
            r_o_free   <= 13'(r_free_cnt);
            r_o_alloc  <= r_alloc;
            r_o_isfree <= r_res_isfree;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_page_number   = r_o_pnum;
    assign o_pages_changed = r_o_chg;
    assign o_free_count    = r_o_free;
    assign o_alloc_total   = r_o_alloc;
    assign o_page_is_free  = r_o_isfree;

    `ASSERT_CLK(a_free_bound, i_clk, i_rst_n, r_free_cnt <= CW'(NUM_PAGES), "free count above page total")
    `ASSERT_CLK(a_no_write_idle, i_clk, i_rst_n, (r_state == S_IDLE || r_state == S_SRCH || r_state == S_QUERY) |-> !we, "map written outside a write phase")
    `ASSERT_CLK(a_alloc_from_mark, i_clk, i_rst_n, ($past(i_rst_n) && r_alloc != $past(r_alloc)) |-> $past(r_state == S_MARK), "allocation count moved without a mark")
    `ASSERT_CLK(a_load_when_free, i_clk, i_rst_n, load_out |-> (!r_ovalid || !i_stall), "held transaction overwritten")

endmodule
